[hw/rtl/atf_pkg.sv]
// ----------------------------------------------------------------------------
// atf_pkg
// Codes, character constants and digit helpers for the address text formatter.
// ----------------------------------------------------------------------------
package atf_pkg;

    localparam int unsigned NUM_GRP = 8;

    localparam logic [1:0] FMT_IPV4 = 2'd0;
    localparam logic [1:0] FMT_IPV6 = 2'd1;
    localparam logic [1:0] FMT_MAC  = 2'd2;

    localparam logic [6:0] CH_COLON = 7'h3a;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_DASH  = 7'h2d;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A_OFS = 7'h57;

    typedef logic [2:0] grp_idx_t;
    typedef logic [2:0] ndig_t;

    // lowercase hex digit
    function automatic logic [6:0] hex_ascii(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10)
        begin
            c = CH_ZERO + {3'b000, n};
        end
        else
        begin
            c = CH_A_OFS + {3'b000, n};
        end
        return c;
    endfunction

    // byte to three BCD digits, double dabble
    function automatic logic [11:0] bcd8(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (s[11:8] >= 4'd5)
            begin
                s[11:8] = s[11:8] + 4'd3;
            end
            if (s[15:12] >= 4'd5)
            begin
                s[15:12] = s[15:12] + 4'd3;
            end
            if (s[19:16] >= 4'd5)
            begin
                s[19:16] = s[19:16] + 4'd3;
            end
            s = s << 1;
        end
        return s[19:8];
    endfunction

    function automatic ndig_t dec_ndig(input logic [7:0] v);
        ndig_t n;
        if (v >= 8'd100)
        begin
            n = 3'd3;
        end
        else if (v >= 8'd10)
        begin
            n = 3'd2;
        end
        else
        begin
            n = 3'd1;
        end
        return n;
    endfunction

    function automatic ndig_t hex_ndig(input logic [15:0] w);
        ndig_t n;
        if (w[15:12] != 4'd0)
        begin
            n = 3'd4;
        end
        else if (w[15:8] != 8'd0)
        begin
            n = 3'd3;
        end
        else if (w[15:4] != 12'd0)
        begin
            n = 3'd2;
        end
        else
        begin
            n = 3'd1;
        end
        return n;
    endfunction

endpackage

[hw/rtl/address_to_text_formatter_unit.sv]
// ----------------------------------------------------------------------------
// address_to_text_formatter_unit
// Formats an IPv4, IPv6 or MAC address as ASCII text, one character per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  addr    | in        | addr_valid/addr_stall | func, address_hi, address_lo
//  char    | out       | char_valid/char_stall | text_char, last_char
//
//  An address of N characters (2..39) holds the character cursor until its
//  last one is produced; one character per cycle goes into the output
//  register unless char_stall holds it. The next address is taken in the
//  cycle the previous last character is produced: no gap between texts.
//  Reset clears the cursor and output valid. char_stall holds the output
//  register and the cursor; addr_stall is high while the cursor is in use.
// ----------------------------------------------------------------------------
module address_to_text_formatter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        addr_valid,
    output logic        addr_stall,
    input  logic [1:0]  func,
    input  logic [63:0] address_hi,
    input  logic [63:0] address_lo,
    output logic        char_valid,
    input  logic        char_stall,
    output logic [6:0]  text_char,
    output logic        last_char
);
    import atf_pkg::*;

    // per-group digits, left aligned, and digit counts
    logic [15:0] dig_reg  [NUM_GRP];
    logic [15:0] dig_next [NUM_GRP];
    ndig_t       ndig_reg  [NUM_GRP];
    ndig_t       ndig_next [NUM_GRP];
    grp_idx_t    last_grp_reg, last_grp_next;
    logic [6:0]  sep_reg, sep_next;
    logic        el_valid_reg, el_valid_next;
    grp_idx_t    el_at_reg, el_at_next;
    grp_idx_t    el_end_reg, el_end_next;

    logic        busy_reg, busy_next;
    grp_idx_t    g_reg, g_next;
    logic [2:0]  p_reg, p_next;

    logic        out_valid_reg;
    logic [6:0]  text_char_reg, text_char_next;
    logic        last_char_reg, last_char_next;

    logic        addr_take;
    logic        out_free;
    logic        emit;
    logic        is_el;
    logic [15:0] cur_dig;
    ndig_t       cur_ndig;
    logic [3:0]  cur_nib;

    logic [15:0] word  [NUM_GRP];
    logic [7:0]  bval;
    logic [11:0] bcd;
    ndig_t       nd;
    logic        run_started;
    logic        run_done;

    // ---------------- load path: address to digit groups ----------------
    always_comb
    begin
        for (int k = 0; k < NUM_GRP; k++)
        begin
            word[k]      = (k < 4) ? address_hi[(3 - (k % 4)) * 16 +: 16]
                                   : address_lo[(3 - (k % 4)) * 16 +: 16];
            dig_next[k]  = 16'd0;
            ndig_next[k] = 3'd1;
        end
        bval          = 8'd0;
        bcd           = 12'd0;
        nd            = 3'd1;
        run_started   = 1'b0;
        run_done      = 1'b0;
        el_valid_next = 1'b0;
        el_at_next    = 3'd0;
        el_end_next   = 3'd0;
        last_grp_next = 3'd3;
        sep_next      = CH_DOT;

        unique case (func)
            FMT_IPV6:
            begin
                last_grp_next = 3'd7;
                sep_next      = CH_COLON;
                for (int k = 0; k < NUM_GRP; k++)
                begin
                    nd           = hex_ndig(word[k]);
                    ndig_next[k] = nd;
                    dig_next[k]  = word[k] << {(3'd4 - nd), 2'b00};
                    if (word[k] == 16'd0 && !run_done)
                    begin
                        if (!run_started)
                        begin
                            run_started = 1'b1;
                            el_at_next  = 3'(k);
                        end
                        el_end_next = 3'(k);
                    end
                    else if (run_started)
                    begin
                        run_done = 1'b1;
                    end
                end
                el_valid_next = run_started;
            end
            FMT_MAC:
            begin
                last_grp_next = 3'd5;
                sep_next      = CH_DASH;
                for (int k = 0; k < 6; k++)
                begin
                    ndig_next[k] = 3'd2;
                    dig_next[k]  = {address_lo[(5 - k) * 8 +: 8], 8'd0};
                end
            end
            default:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    bval         = address_lo[(3 - k) * 8 +: 8];
                    bcd          = bcd8(bval);
                    nd           = dec_ndig(bval);
                    ndig_next[k] = nd;
                    dig_next[k]  = {bcd, 4'd0} << {(3'd3 - nd), 2'b00};
                end
            end
        endcase
    end

    // ---------------- character cursor ----------------
    assign out_free = !out_valid_reg || !char_stall;
    assign emit     = busy_reg && out_free;
    assign cur_dig  = dig_reg[g_reg];
    assign cur_ndig = ndig_reg[g_reg];
    assign is_el    = el_valid_reg && (g_reg == el_at_reg);

    always_comb
    begin
        unique case (p_reg)
            3'd1:    cur_nib = cur_dig[15:12];
            3'd2:    cur_nib = cur_dig[11:8];
            3'd3:    cur_nib = cur_dig[7:4];
            3'd4:    cur_nib = cur_dig[3:0];
            default: cur_nib = 4'd0;
        endcase
    end

    // character and last flag at the cursor
    always_comb
    begin
        priority if (p_reg == 3'd0)
        begin
            text_char_next = is_el ? CH_COLON : sep_reg;
        end
        else if (is_el)
        begin
            text_char_next = CH_COLON;
        end
        else
        begin
            text_char_next = hex_ascii(cur_nib);
        end

        if (is_el)
        begin
            last_char_next = (el_end_reg == 3'd7) && (p_reg == 3'd1);
        end
        else
        begin
            last_char_next = (g_reg == last_grp_reg) && (p_reg == cur_ndig);
        end
    end

    assign addr_stall = busy_reg && !(emit && last_char_next);
    assign addr_take  = addr_valid && !addr_stall;

    // cursor advance
    always_comb
    begin
        g_next    = g_reg;
        p_next    = p_reg;
        busy_next = busy_reg;
        priority if (addr_take)
        begin
            busy_next = 1'b1;
            g_next    = 3'd0;
            p_next    = (el_valid_next && el_at_next == 3'd0) ? 3'd0 : 3'd1;
        end
        else if (emit)
        begin
            if (last_char_next)
            begin
                busy_next = 1'b0;
            end
            else if (is_el)
            begin
                if (el_end_reg == 3'd7)
                begin
                    p_next = 3'd1;
                end
                else
                begin
                    g_next = el_end_reg + 3'd1;
                    p_next = 3'd0;
                end
            end
            else if (p_reg == cur_ndig)
            begin
                g_next = g_reg + 3'd1;
                p_next = 3'd0;
            end
            else
            begin
                p_next = p_reg + 3'd1;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            g_reg         <= 3'd0;
            p_reg         <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            g_reg    <= g_next;
            p_reg    <= p_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (addr_take)
        begin
            for (int k = 0; k < NUM_GRP; k++)
            begin
                dig_reg[k]  <= dig_next[k];
                ndig_reg[k] <= ndig_next[k];
            end
            last_grp_reg <= last_grp_next;
            sep_reg      <= sep_next;
            el_valid_reg <= el_valid_next;
            el_at_reg    <= el_at_next;
            el_end_reg   <= el_end_next;
        end
        if (emit)
        begin
            text_char_reg <= text_char_next;
            last_char_reg <= last_char_next;
        end
    end

    assign char_valid = out_valid_reg;
    assign text_char  = text_char_reg;
    assign last_char  = last_char_reg;

endmodule
